/* hdl/distributed_mutex_node_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the mutual-exclusion node
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISTRIBUTED_MUTEX_NODE_TOP_MACROS_SVH
`define DISTRIBUTED_MUTEX_NODE_TOP_MACROS_SVH

// Same-cycle implication
`define DMN_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DMN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dmn_pkg.sv */
// ----------------------------------------------------------------------------
// dmn_pkg
// Shared types, codes and helpers of the mutual-exclusion node.
// ----------------------------------------------------------------------------
package dmn_pkg;

    // Field widths, result limit and queue depth
    localparam int TIME_W      = 15;
    localparam int ID_W        = 4;
    localparam int CNT_W       = 4;
    localparam int MAX_RESULTS = 15;
    localparam int QDEPTH      = 2;

    typedef logic [ID_W-1:0]   node_t;
    typedef logic [TIME_W-1:0] stamp_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam stamp_t TIME_MAX = '1;

    // Configuration register indexes
    localparam logic [0:0] CFG_NODE_ID    = 1'b0;
    localparam logic [0:0] CFG_PEER_COUNT = 1'b1;

    // Local actions
    typedef enum logic [1:0] {
        ACT_REQUEST = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_MESSAGE = 2'd2,
        ACT_DONE    = 2'd3
    } action_t;

    // Arriving message kinds
    typedef enum logic [1:0] {
        MSG_REQUEST = 2'd0,
        MSG_REPLY   = 2'd1,
        MSG_DONE    = 2'd2
    } msg_kind_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_REQ   = 3'd0,
        KIND_REPLY = 3'd1,
        KIND_DONE  = 3'd2,
        KIND_GRANT = 3'd3,
        KIND_NONE  = 3'd4
    } out_kind_t;

    // Work handed from the front end to the back end
    typedef enum logic [1:0] {
        OP_SINGLE  = 2'd0,
        OP_PUSH    = 2'd1,
        OP_BCAST   = 2'd2,
        OP_RELEASE = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t   op;
        out_kind_t kind;
        node_t     dest;
        stamp_t    stamp;
        logic      grant;
        logic      all_done;
        cnt_t      count;
    } cmd_t;

    // Saturating Lamport increment
    function automatic stamp_t tick(input stamp_t t);
        return (t == TIME_MAX) ? t : t + 1'b1;
    endfunction

endpackage

/* hdl/distributed_mutex_node_top.sv */
// ----------------------------------------------------------------------------
// distributed_mutex_node_top
// One node of Ricart-Agrawala mutual exclusion with a saturating Lamport
// clock. The front end takes one transaction per cycle while its two-entry
// command queue has room and updates the protocol state at once; the back
// end issues the results through a registered output, one per cycle while
// the result channel is not stalled. An item that yields a single result
// (reply, grant, deferral or none) passes through the command queue and the
// output register. A broadcast pops its command, then steps through the
// participant slots from 0 up to the last node that it addresses (slot 0
// alone when it addresses nobody), skipping its own slot when it lies below
// that node, and then issues a grant if one is due; it stops after fifteen
// messages. A release reads the top of the deferred stack and then issues
// one reply per entry, at most fifteen. The deferred stack has a single
// read port; stalls on the result channel hold the back end.
// ----------------------------------------------------------------------------
`include "distributed_mutex_node_top_macros.svh"

module distributed_mutex_node_top
#(
    parameter int MAX_NODES = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    // Configuration
    input  logic            cfg_we,
    input  logic [0:0]      cfg_index,
    input  logic [3:0]      cfg_data,
    // Input channel
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      action,
    input  logic [1:0]      msg_kind,
    input  dmn_pkg::node_t  sender,
    input  dmn_pkg::stamp_t msg_time,
    // Result channel
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      out_kind,
    output dmn_pkg::node_t  dest,
    output dmn_pkg::stamp_t stamp,
    output logic            all_done,
    output logic            last
);

    dmn_pkg::node_t node_id_reg;
    dmn_pkg::node_t peer_count_reg;
    dmn_pkg::node_t lim;

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    dmn_pkg::cmd_t  cmd;
    dmn_pkg::cmd_t  q_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg    <= dmn_pkg::node_t'(1);
            peer_count_reg <= dmn_pkg::node_t'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dmn_pkg::CFG_NODE_ID:    node_id_reg    <= cfg_data;
                dmn_pkg::CFG_PEER_COUNT: peer_count_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Highest participant that is addressed
    assign lim = (int'(peer_count_reg) > MAX_NODES - 1)
                 ? dmn_pkg::node_t'(MAX_NODES - 1) : peer_count_reg;

    dmn_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .msg_kind (msg_kind),
        .sender   (sender),
        .msg_time (msg_time),
        .node_id  (node_id_reg),
        .lim      (lim),
        .q_full   (q_full),
        .q_push   (q_push),
        .cmd      (cmd)
    );

    dmn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    dmn_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .node_id   (node_id_reg),
        .lim       (lim),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_kind  (out_kind),
        .dest      (dest),
        .stamp     (stamp),
        .all_done  (all_done),
        .last      (last)
    );

    // Checks
    `DMN_ASSERT_IMPLIES(a_grant_to_self, out_valid && (out_kind == dmn_pkg::KIND_GRANT), dest == node_id_reg, "grant not addressed to this node")
    `DMN_ASSERT_IMPLIES(a_none_dest_zero, out_valid && (out_kind == dmn_pkg::KIND_NONE), dest == '0, "empty result carries a destination")
    `DMN_ASSERT_IMPLIES(a_pop_not_empty, q_pop, !q_empty, "command popped from an empty queue")
    `DMN_ASSERT_NEXT(a_full_holds, q_full && !q_pop, q_full, "queue lost an entry without a pop")

endmodule

/* hdl/dmn_queue.sv */
// ----------------------------------------------------------------------------
// dmn_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dmn_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dmn_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output dmn_pkg::cmd_t pop_data,
    output logic          empty
);

    localparam int AW = (dmn_pkg::QDEPTH > 1) ? $clog2(dmn_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(dmn_pkg::QDEPTH + 1);

    dmn_pkg::cmd_t   entry_reg [dmn_pkg::QDEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   fill_next;

    assign full     = (fill_reg == CW'(dmn_pkg::QDEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == dmn_pkg::QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == dmn_pkg::QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/dmn_front.sv */
// ----------------------------------------------------------------------------
// dmn_front
// Accepts input transactions, keeps the node's protocol state and Lamport
// clock, and classifies each item into one back-end command.
// ----------------------------------------------------------------------------
module dmn_front
#(
    parameter int MAX_NODES = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     action,
    input  logic [1:0]     msg_kind,
    input  dmn_pkg::node_t sender,
    input  dmn_pkg::stamp_t msg_time,
    input  dmn_pkg::node_t node_id,
    input  dmn_pkg::node_t lim,
    input  logic           q_full,
    output logic           q_push,
    output dmn_pkg::cmd_t  cmd
);

    localparam int PW = $clog2(MAX_NODES + 1);
    localparam logic [dmn_pkg::TIME_W:0] TMAX_EXT = {1'b0, dmn_pkg::TIME_MAX};

    // Protocol state
    dmn_pkg::stamp_t        clock_reg;
    dmn_pkg::stamp_t        clock_next;
    logic                   requesting_reg;
    logic                   requesting_next;
    dmn_pkg::stamp_t        req_stamp_reg;
    dmn_pkg::stamp_t        req_stamp_next;
    logic [MAX_NODES-1:0]   reply_bits_reg;
    logic [MAX_NODES-1:0]   reply_bits_next;
    logic [PW-1:0]          def_count_reg;
    logic [PW-1:0]          def_count_next;
    logic [MAX_NODES-1:0]   finished_reg;
    logic [MAX_NODES-1:0]   finished_next;

    // Working values
    logic                   accept;
    logic [MAX_NODES-1:0]   group_mask;
    logic [MAX_NODES-1:0]   own_bit;
    logic [MAX_NODES-1:0]   snd_bit;
    logic [MAX_NODES-1:0]   reply_merged;
    dmn_pkg::stamp_t        ticked;
    dmn_pkg::stamp_t        later;
    dmn_pkg::stamp_t        pulled;
    dmn_pkg::stamp_t        pulled_tick;
    logic [dmn_pkg::TIME_W:0] rel_sum;
    dmn_pkg::stamp_t        rel_clock;
    dmn_pkg::cnt_t          rel_n;
    logic                   ours_older;
    logic                   stack_free;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;
    assign q_push   = accept;

    // Participant masks
    always_comb
    begin
        for (int i = 0; i < MAX_NODES; i++)
        begin
            group_mask[i] = (i <= int'(lim));
            own_bit[i]    = (int'(node_id) == i);
            snd_bit[i]    = (int'(sender) == i);
        end
    end

    // Clock arithmetic
    assign ticked       = dmn_pkg::tick(clock_reg);
    assign later        = (clock_reg > msg_time) ? clock_reg : msg_time;
    assign pulled       = dmn_pkg::tick(later);
    assign pulled_tick  = dmn_pkg::tick(pulled);
    assign rel_sum      = (dmn_pkg::TIME_W + 1)'(clock_reg) + (dmn_pkg::TIME_W + 1)'(def_count_reg);
    assign rel_clock    = (rel_sum > TMAX_EXT) ? dmn_pkg::TIME_MAX : rel_sum[dmn_pkg::TIME_W-1:0];
    assign rel_n        = (int'(def_count_reg) > dmn_pkg::MAX_RESULTS)
                          ? dmn_pkg::cnt_t'(dmn_pkg::MAX_RESULTS) : dmn_pkg::cnt_t'(def_count_reg);
    assign reply_merged = reply_bits_reg | snd_bit;

    // Pending request (stamp, id) is older than the arriving one
    assign ours_older = requesting_reg &&
                        ((req_stamp_reg < msg_time) ||
                         ((req_stamp_reg == msg_time) && (node_id < sender)));
    assign stack_free = (int'(def_count_reg) < MAX_NODES);

    // Classification and state update
    always_comb
    begin
        clock_next      = clock_reg;
        requesting_next = requesting_reg;
        req_stamp_next  = req_stamp_reg;
        reply_bits_next = reply_bits_reg;
        def_count_next  = def_count_reg;
        finished_next   = finished_reg;

        cmd.op       = dmn_pkg::OP_SINGLE;
        cmd.kind     = dmn_pkg::KIND_NONE;
        cmd.dest     = '0;
        cmd.stamp    = clock_reg;
        cmd.grant    = 1'b0;
        cmd.count    = '0;

        case (dmn_pkg::action_t'(action))
            dmn_pkg::ACT_REQUEST:
            begin
                if (!requesting_reg)
                begin
                    clock_next      = ticked;
                    req_stamp_next  = ticked;
                    requesting_next = 1'b1;
                    reply_bits_next = own_bit;
                    cmd.op          = dmn_pkg::OP_BCAST;
                    cmd.kind        = dmn_pkg::KIND_REQ;
                    cmd.stamp       = ticked;
                    cmd.grant       = ((own_bit & group_mask) == group_mask);
                end
            end
            dmn_pkg::ACT_RELEASE:
            begin
                requesting_next = 1'b0;
                reply_bits_next = '0;
                def_count_next  = '0;
                clock_next      = rel_clock;
                cmd.op          = dmn_pkg::OP_RELEASE;
                cmd.kind        = dmn_pkg::KIND_REPLY;
                cmd.count       = rel_n;
            end
            dmn_pkg::ACT_DONE:
            begin
                clock_next    = ticked;
                finished_next = finished_reg | own_bit;
                cmd.op        = dmn_pkg::OP_BCAST;
                cmd.kind      = dmn_pkg::KIND_DONE;
                cmd.stamp     = ticked;
            end
            dmn_pkg::ACT_MESSAGE:
            begin
                clock_next = pulled;
                cmd.stamp  = pulled;
                case (dmn_pkg::msg_kind_t'(msg_kind))
                    dmn_pkg::MSG_REQUEST:
                    begin
                        if (ours_older && stack_free)
                        begin
                            // Defer: the back end stacks the sender
                            def_count_next = def_count_reg + 1'b1;
                            cmd.op         = dmn_pkg::OP_PUSH;
                            cmd.dest       = sender;
                        end
                        else
                        begin
                            clock_next = pulled_tick;
                            cmd.kind   = dmn_pkg::KIND_REPLY;
                            cmd.dest   = sender;
                            cmd.stamp  = pulled_tick;
                        end
                    end
                    dmn_pkg::MSG_REPLY:
                    begin
                        if (requesting_reg && (snd_bit != '0) && ((reply_bits_reg & snd_bit) == '0))
                        begin
                            reply_bits_next = reply_merged;
                            if ((reply_merged & group_mask) == group_mask)
                            begin
                                cmd.kind = dmn_pkg::KIND_GRANT;
                                cmd.dest = node_id;
                            end
                        end
                    end
                    dmn_pkg::MSG_DONE:
                    begin
                        finished_next = finished_reg | snd_bit;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        cmd.all_done = ((finished_next & group_mask) == group_mask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg      <= '0;
            requesting_reg <= 1'b0;
            req_stamp_reg  <= '0;
            reply_bits_reg <= '0;
            def_count_reg  <= '0;
            finished_reg   <= {{(MAX_NODES-1){1'b0}}, 1'b1};
        end
        else if (accept)
        begin
            clock_reg      <= clock_next;
            requesting_reg <= requesting_next;
            req_stamp_reg  <= req_stamp_next;
            reply_bits_reg <= reply_bits_next;
            def_count_reg  <= def_count_next;
            finished_reg   <= finished_next;
        end
    end

endmodule

/* hdl/dmn_back.sv */
// ----------------------------------------------------------------------------
// dmn_back
// Carries out queued commands: walks broadcasts, pops the deferred stack on
// release and drives the registered result channel, one per unstalled cycle.
// ----------------------------------------------------------------------------
module dmn_back
#(
    parameter int MAX_NODES = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  dmn_pkg::cmd_t   q_data,
    output logic            q_pop,
    input  dmn_pkg::node_t  node_id,
    input  dmn_pkg::node_t  lim,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      out_kind,
    output dmn_pkg::node_t  dest,
    output dmn_pkg::stamp_t stamp,
    output logic            all_done,
    output logic            last
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int PW = $clog2(MAX_NODES + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BCAST = 4'b0010,
        ST_GRANT = 4'b0100,
        ST_REL   = 4'b1000
    } back_state_t;

    // Deferred stack
    dmn_pkg::node_t stack_mem [MAX_NODES];
    dmn_pkg::node_t rd_data_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic           mem_re;
    logic [AW-1:0]  mem_ra;

    // Sequencer state
    back_state_t       state_reg;
    back_state_t       state_next;
    logic [PW-1:0]     ptr_reg;
    logic [PW-1:0]     ptr_next;
    logic [PW-1:0]     ptr_dec;
    dmn_pkg::node_t    idx_reg;
    dmn_pkg::node_t    idx_next;
    dmn_pkg::cnt_t     cnt_reg;
    dmn_pkg::cnt_t     cnt_next;
    dmn_pkg::cnt_t     cnt_inc;
    dmn_pkg::cnt_t     rem_reg;
    dmn_pkg::cnt_t     rem_next;
    dmn_pkg::out_kind_t cur_kind_reg;
    dmn_pkg::out_kind_t cur_kind_next;
    dmn_pkg::stamp_t   cur_stamp_reg;
    dmn_pkg::stamp_t   cur_stamp_next;
    dmn_pkg::stamp_t   stamp_inc;
    logic              cur_grant_reg;
    logic              cur_grant_next;
    logic              cur_done_reg;
    logic              cur_done_next;

    // Broadcast walk helpers
    logic              is_target;
    logic              own_ahead;
    dmn_pkg::node_t    rem_after;
    logic              more_bc;

    // Result being issued this cycle
    logic               slot_free;
    logic               emit;
    dmn_pkg::out_kind_t e_kind;
    dmn_pkg::node_t     e_dest;
    dmn_pkg::stamp_t    e_stamp;
    logic               e_last;
    logic               e_all_done;

    // Output register
    logic               out_valid_reg;
    dmn_pkg::out_kind_t out_kind_reg;
    dmn_pkg::node_t     dest_reg;
    dmn_pkg::stamp_t    stamp_reg;
    logic               all_done_reg;
    logic               last_reg;

    assign slot_free = !out_valid_reg || !out_stall;
    assign ptr_dec   = ptr_reg - 1'b1;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign stamp_inc = dmn_pkg::tick(cur_stamp_reg);
    assign is_target = (idx_reg != node_id);
    assign own_ahead = (node_id > idx_reg) && (node_id <= lim);
    assign rem_after = lim - idx_reg - dmn_pkg::node_t'(own_ahead);
    assign more_bc   = (cnt_inc != dmn_pkg::cnt_t'(dmn_pkg::MAX_RESULTS)) &&
                       ((rem_after != '0) || cur_grant_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        cur_kind_next  = cur_kind_reg;
        cur_stamp_next = cur_stamp_reg;
        cur_grant_next = cur_grant_reg;
        cur_done_next  = cur_done_reg;

        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = ptr_reg[AW-1:0];
        mem_re     = 1'b0;
        mem_ra     = ptr_dec[AW-1:0];
        emit       = 1'b0;
        e_kind     = dmn_pkg::KIND_NONE;
        e_dest     = '0;
        e_stamp    = cur_stamp_reg;
        e_last     = 1'b1;
        e_all_done = cur_done_reg;

        case (state_reg)
            ST_IDLE:
            begin
                e_all_done = q_data.all_done;
                e_stamp    = q_data.stamp;
                if (!q_empty && slot_free)
                begin
                    q_pop          = 1'b1;
                    cur_kind_next  = q_data.kind;
                    cur_stamp_next = q_data.stamp;
                    cur_grant_next = q_data.grant;
                    cur_done_next  = q_data.all_done;
                    case (q_data.op)
                        dmn_pkg::OP_SINGLE:
                        begin
                            emit   = 1'b1;
                            e_kind = q_data.kind;
                            e_dest = q_data.dest;
                        end
                        dmn_pkg::OP_PUSH:
                        begin
                            mem_we   = 1'b1;
                            ptr_next = ptr_reg + 1'b1;
                            emit     = 1'b1;
                        end
                        dmn_pkg::OP_BCAST:
                        begin
                            idx_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_BCAST;
                        end
                        dmn_pkg::OP_RELEASE:
                        begin
                            if (q_data.count == '0)
                            begin
                                emit     = 1'b1;
                                ptr_next = '0;
                            end
                            else
                            begin
                                // Fetch the top of stack ahead of the first reply
                                mem_re     = 1'b1;
                                ptr_next   = ptr_dec;
                                rem_next   = q_data.count;
                                state_next = ST_REL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BCAST:
            begin
                e_kind = cur_kind_reg;
                e_dest = idx_reg;
                if (is_target)
                begin
                    if (slot_free)
                    begin
                        emit     = 1'b1;
                        e_last   = !more_bc;
                        cnt_next = cnt_inc;
                        if (!more_bc)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (rem_after != '0)
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                        else
                        begin
                            state_next = ST_GRANT;
                        end
                    end
                end
                else if (rem_after != '0)
                begin
                    // Own slot: skip it
                    idx_next = idx_reg + 1'b1;
                end
                else if (cur_grant_reg)
                begin
                    state_next = ST_GRANT;
                end
                else if (slot_free)
                begin
                    // Nobody else to address
                    emit       = 1'b1;
                    e_kind     = dmn_pkg::KIND_NONE;
                    e_dest     = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_GRANT:
            begin
                e_kind = dmn_pkg::KIND_GRANT;
                e_dest = node_id;
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_REL:
            begin
                e_kind  = dmn_pkg::KIND_REPLY;
                e_dest  = rd_data_reg;
                e_stamp = stamp_inc;
                e_last  = (rem_reg == dmn_pkg::cnt_t'(1));
                if (slot_free)
                begin
                    emit           = 1'b1;
                    cur_stamp_next = stamp_inc;
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg != dmn_pkg::cnt_t'(1))
                    begin
                        mem_re   = 1'b1;
                        ptr_next = ptr_dec;
                    end
                    else
                    begin
                        ptr_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            if (slot_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    // Current command and result payload
    always_ff @(posedge clk)
    begin
        cur_kind_reg  <= cur_kind_next;
        cur_stamp_reg <= cur_stamp_next;
        cur_grant_reg <= cur_grant_next;
        cur_done_reg  <= cur_done_next;
        if (slot_free && emit)
        begin
            out_kind_reg <= e_kind;
            dest_reg     <= e_dest;
            stamp_reg    <= e_stamp;
            all_done_reg <= e_all_done;
            last_reg     <= e_last;
        end
    end

    // Stack memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_wa] <= q_data.dest;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_ra];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign dest      = dest_reg;
    assign stamp     = stamp_reg;
    assign all_done  = all_done_reg;
    assign last      = last_reg;

endmodule
